// ===== rtl/tmma_pkg.sv =====
package tmma_pkg;

  // Fixed field widths.
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned SIZE_W = 4;

  // Width of a flattened cell address before it is cut to the store depth.
  localparam int unsigned CELL_W = 2 * IDX_W + 1;

  // Default tile edge and reset value of the tile size register.
  localparam int unsigned TILE_MAX_DEF = 8;
  localparam logic [SIZE_W-1:0] TILE_SIZE_RST = SIZE_W'(8);

  // Command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Saturation limits of the accumulator.
  localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] a_value;
    logic signed [VAL_W-1:0] b_value;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic                    tile_done;
    logic                    emit_now;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] c_value;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic                    last_result;
  } out_t;

  // A classified item as it waits in the queue.
  typedef struct packed {
    in_t  item;
    logic store_en;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } back_state_e;

  // Two's complement add that clamps to the signed range on overflow.
  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      return a[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end
    return s;
  endfunction

endpackage

// ===== rtl/tile_matrix_multiply_accumulate.sv =====
// Channel  | Valid        | Ready        | Payload
// ---------+--------------+--------------+-----------------------------
// in       | in_valid_i   | in_ready_o   | in_item_i  (A, B, row, col, flags)
// out      | out_valid_o  | out_ready_i  | out_item_o (C entry, row, col, last)
// cfg      | cfg_valid_i  | cfg_ready_o  | cfg_data_i (tile size)
//
// An item that only loads A and B is taken by the back end in its idle state.
// With tile_done it runs an n*n*n multiply-accumulate pass: one shared MAC does one product a cycle.
// With emit_now it streams n*n C entries, each read in ST_EMIT_RD and loaded in ST_EMIT_LD.
// A two-entry item queue lets the input side run ahead while the back end works or
// the output stalls. After reset the block is ready at once; C reads as zero.
module tile_matrix_multiply_accumulate #(
  parameter int unsigned TILE_MAX = tmma_pkg::TILE_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tmma_pkg::in_t                in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tmma_pkg::out_t               out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tmma_pkg::SIZE_W-1:0]  cfg_data_i
);

  logic [tmma_pkg::SIZE_W-1:0] tile_size_q;
  logic                        cmd_valid;
  logic                        cmd_ready;
  tmma_pkg::cmd_t              cmd;

  // Tile size register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= tmma_pkg::TILE_SIZE_RST;
    end else if (cfg_valid_i) begin
      tile_size_q <= cfg_data_i;
    end
  end

  tmma_front #(.TILE_MAX(TILE_MAX)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  tmma_back #(.TILE_MAX(TILE_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .tile_size_i (tile_size_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/tmma_ram.sv =====
module tmma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/tmma_front.sv =====
module tmma_front #(
  parameter int unsigned TILE_MAX = tmma_pkg::TILE_MAX_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tmma_pkg::in_t   in_item_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output tmma_pkg::cmd_t  cmd_o
);

  tmma_pkg::cmd_t                   queue_q [tmma_pkg::QUEUE_DEPTH];
  logic [tmma_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [tmma_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [tmma_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  tmma_pkg::cmd_t                   cmd_new;
  logic                             push, pop;

  // Classify the item: loads outside the store are dropped.
  always_comb begin
    cmd_new.item     = in_item_i;
    cmd_new.store_en =
      (tmma_pkg::CELL_W'(in_item_i.row_index) < tmma_pkg::CELL_W'(TILE_MAX)) &&
      (tmma_pkg::CELL_W'(in_item_i.col_index) < tmma_pkg::CELL_W'(TILE_MAX));
  end

  assign in_ready_o  = (cnt_q != tmma_pkg::QCNT_W'(tmma_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tmma_pkg::QPTR_W'(tmma_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tmma_pkg::QPTR_W'(tmma_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/tmma_back.sv =====
module tmma_back #(
  parameter int unsigned TILE_MAX = tmma_pkg::TILE_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  tmma_pkg::cmd_t                cmd_i,
  input  logic [tmma_pkg::SIZE_W-1:0]   tile_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tmma_pkg::out_t                out_item_o
);

  localparam int unsigned DEPTH = TILE_MAX * TILE_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Flatten a row and column into a store address.
  function automatic logic [AW-1:0] cell_addr(logic [tmma_pkg::IDX_W-1:0] r,
                                              logic [tmma_pkg::IDX_W-1:0] c);
    logic [tmma_pkg::CELL_W-1:0] t;
    t = tmma_pkg::CELL_W'(r) * tmma_pkg::CELL_W'(TILE_MAX) + tmma_pkg::CELL_W'(c);
    return t[AW-1:0];
  endfunction

  tmma_pkg::back_state_e              state_q, state_d;
  logic [tmma_pkg::IDX_W-1:0]         i_q, i_d, j_q, j_d, k_q, k_d;
  logic                               emit_q, emit_d;
  logic [tmma_pkg::SIZE_W-1:0]        n, n_m1;
  logic                               i_last, j_last, k_last;

  logic                               ab_we;
  logic [AW-1:0]                      ab_waddr, a_raddr, b_raddr, c_raddr;
  logic [tmma_pkg::VAL_W-1:0]         a_rdata, b_rdata;
  logic [tmma_pkg::ACC_W-1:0]         c_rdata;
  logic                               c_we;
  logic [DEPTH-1:0]                   c_vld_q, c_vld_d;
  logic                               rd_cvld_q;
  logic                               c_clear;

  logic                               issue;
  logic                               s1_vld_q, s1_first_q, s1_last_q;
  logic [AW-1:0]                      s1_addr_q;
  logic                               s2_vld_q, s2_first_q, s2_last_q;
  logic [AW-1:0]                      s2_addr_q;
  logic signed [tmma_pkg::ACC_W-1:0]  p_d, p_q;
  logic [tmma_pkg::ACC_W-1:0]         cbase_q, acc_q, acc_d;

  logic                               out_load;
  logic                               out_vld_q, out_vld_d;
  tmma_pkg::out_t                     out_q;

  // Active tile edge, clamped to the supported range.
  always_comb begin
    if (tile_size_i == '0) begin
      n = tmma_pkg::SIZE_W'(1);
    end else if (tile_size_i > tmma_pkg::SIZE_W'(TILE_MAX)) begin
      n = tmma_pkg::SIZE_W'(TILE_MAX);
    end else begin
      n = tile_size_i;
    end
  end

  assign n_m1   = n - 1'b1;
  assign i_last = (tmma_pkg::SIZE_W'(i_q) == n_m1);
  assign j_last = (tmma_pkg::SIZE_W'(j_q) == n_m1);
  assign k_last = (tmma_pkg::SIZE_W'(k_q) == n_m1);

  // Store addresses: A by row, B by column, C at the current cell.
  assign ab_waddr = cell_addr(cmd_i.item.row_index, cmd_i.item.col_index);
  assign a_raddr  = cell_addr(i_q, k_q);
  assign b_raddr  = cell_addr(k_q, j_q);
  assign c_raddr  = cell_addr(i_q, j_q);

  tmma_ram #(.WIDTH(tmma_pkg::VAL_W), .DEPTH(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (ab_we),
    .waddr_i (ab_waddr),
    .wdata_i (cmd_i.item.a_value),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  tmma_ram #(.WIDTH(tmma_pkg::VAL_W), .DEPTH(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (ab_we),
    .waddr_i (ab_waddr),
    .wdata_i (cmd_i.item.b_value),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  tmma_ram #(.WIDTH(tmma_pkg::ACC_W), .DEPTH(DEPTH)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (s2_addr_q),
    .wdata_i (acc_d),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Sequencer: load, multiply-accumulate pass, drain, and stream C when emit_now asks for it.
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    emit_d      = emit_q;
    cmd_ready_o = 1'b0;
    ab_we       = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    c_clear     = 1'b0;
    case (state_q)
      tmma_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (cmd_valid_i) begin
          ab_we  = cmd_i.store_en;
          emit_d = cmd_i.item.emit_now;
          if (cmd_i.item.tile_done) begin
            state_d = tmma_pkg::ST_MAC;
          end else if (cmd_i.item.emit_now) begin
            state_d = tmma_pkg::ST_EMIT_RD;
          end
        end
      end
      tmma_pkg::ST_MAC: begin
        issue = 1'b1;
        if (k_last) begin
          k_d = '0;
          if (j_last) begin
            j_d = '0;
            if (i_last) begin
              i_d     = '0;
              state_d = tmma_pkg::ST_DRAIN;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      tmma_pkg::ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = emit_q ? tmma_pkg::ST_EMIT_RD : tmma_pkg::ST_IDLE;
        end
      end
      tmma_pkg::ST_EMIT_RD: begin
        // Read only when the output register is free at the next edge.
        if (!out_vld_q || out_ready_i) begin
          state_d = tmma_pkg::ST_EMIT_LD;
        end
      end
      tmma_pkg::ST_EMIT_LD: begin
        out_load = 1'b1;
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d     = '0;
            c_clear = 1'b1;
            state_d = tmma_pkg::ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = tmma_pkg::ST_EMIT_RD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = tmma_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_d = tmma_pkg::ST_IDLE;
      end
    endcase
  end

  // Product of the stage-one operands, exact as a signed 64-bit integer (Q63.0).
  assign p_d = tmma_pkg::ACC_W'($signed(a_rdata)) * tmma_pkg::ACC_W'($signed(b_rdata));

  // Saturating accumulate; the first term of a cell starts from stored C.
  assign acc_d = tmma_pkg::sat_add(s2_first_q ? cbase_q : acc_q, p_q);
  assign c_we  = s2_vld_q && s2_last_q;

  // Valid bits of C: a cell that is not valid reads as zero.
  always_comb begin
    c_vld_d = c_vld_q;
    if (c_clear) begin
      c_vld_d = '0;
    end
    if (c_we) begin
      c_vld_d[s2_addr_q] = 1'b1;
    end
  end

  assign out_vld_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tmma_pkg::ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      emit_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      c_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      emit_q    <= emit_d;
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      c_vld_q   <= c_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers of the accumulate pipeline and the output item.
  always_ff @(posedge clk_i) begin
    rd_cvld_q  <= c_vld_q[c_raddr];
    s1_first_q <= (k_q == '0);
    s1_last_q  <= k_last;
    s1_addr_q  <= c_raddr;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_addr_q  <= s1_addr_q;
    p_q        <= p_d;
    cbase_q    <= rd_cvld_q ? c_rdata : '0;
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    if (out_load) begin
      out_q.c_value     <= rd_cvld_q ? c_rdata : '0;
      out_q.out_row     <= i_q;
      out_q.out_col     <= j_q;
      out_q.last_result <= i_last && j_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
